// File: rtl/swd_pkg.sv
// ----------------------------------------------------------------------------
// Serial wire debug host package
// Shared types, codes and constants for the transaction engine.
// ----------------------------------------------------------------------------
package swd_pkg;

  localparam int HDR_W        = 8;
  localparam int DATA_W       = 32;
  localparam int BC_W         = 7;
  localparam int ACK_W        = 3;
  localparam int STATUS_W     = 2;
  localparam int OP_W         = 2;
  localparam int RETRY_W      = 8;
  localparam int WAIT_W       = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam int RESET_HIGH_BITS = 55;
  localparam int REQ_BITS        = 8;
  localparam int SWITCH_BITS     = 16;
  localparam int TRAIL_BITS      = 2;

  localparam logic [15:0] SWITCH_SEQ        = 16'hE79E;
  localparam logic [15:0] PARITY_NIBBLE_LUT = 16'h6996;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 8'd50;
  localparam logic [WAIT_W-1:0]  WAIT_TICKS_RESET  = 16'd10;

  localparam logic [OP_W-1:0] OP_READ   = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LRESET = 2'd2;

  localparam logic [ACK_W-1:0] ACK_OK   = 3'd1;
  localparam logic [ACK_W-1:0] ACK_WAIT = 3'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAULT     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS  = 1'd1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified bit-period request.
  typedef struct packed {
    logic              start_ok;
    logic [OP_W-1:0]   opcode;
    logic [HDR_W-1:0]  header;
    logic [DATA_W-1:0] wdata;
    logic              wpar;
    logic              line_in;
  } item_t;

  function automatic logic even_parity(input logic [DATA_W-1:0] w);
    logic [15:0] f16;
    logic [7:0]  f8;
    logic [3:0]  f4;
    f16 = w[31:16] ^ w[15:0];
    f8  = f16[15:8] ^ f16[7:0];
    f4  = f8[7:4] ^ f8[3:0];
    return PARITY_NIBBLE_LUT[f4];
  endfunction

endpackage

// File: rtl/swd_if.sv
// ----------------------------------------------------------------------------
// Serial wire debug host channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface swd_cmd_if;
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic [swd_pkg::OP_W-1:0]      opcode;
  logic [swd_pkg::HDR_W-1:0]     request_header;
  logic [swd_pkg::DATA_W-1:0]    write_data;
  logic                          line_in;

  modport source (output valid, start_req, opcode, request_header, write_data, line_in,
                  input ready);
  modport sink (input valid, start_req, opcode, request_header, write_data, line_in,
                output ready);
endinterface

interface swd_res_if;
  logic                          valid;
  logic                          ready;
  logic                          line_out;
  logic                          line_drive;
  logic                          clock_active;
  logic                          busy_res;
  logic                          done_res;
  logic [swd_pkg::STATUS_W-1:0]  status;
  logic [swd_pkg::DATA_W-1:0]    read_data;

  modport source (output valid, line_out, line_drive, clock_active, busy_res, done_res,
                  status, read_data, input ready);
  modport sink (input valid, line_out, line_drive, clock_active, busy_res, done_res,
                status, read_data, output ready);
endinterface

interface swd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [swd_pkg::CFG_IDX_W-1:0]   index;
  logic [swd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/swd_host_transaction_engine_unit.sv
// ----------------------------------------------------------------------------
// Serial wire debug host transaction engine
// Front end, request queue and bit-period engine of the debug host.
// ----------------------------------------------------------------------------
// Each request is one bit period; its result passes the front register, the
// queue and the engine output register on its way out.
// Throughput is one request per clock while the result channel does not stall.
// A four-entry queue lets the front end keep accepting while results stall.
// Synchronous reset returns the engine to idle, empties the queue and loads
// retry_limit with 50 and wait_ticks with 10.
module swd_host_transaction_engine_unit (
  input  logic       clk,
  input  logic       rst,
  swd_cmd_if.sink    cmd,
  swd_res_if.source  res,
  swd_cfg_if.sink    cfg
);

  swd_pkg::item_t front_item;
  logic           front_valid;
  logic           front_ready;
  swd_pkg::item_t queue_item;
  logic           queue_valid;
  logic           queue_ready;

  swd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .item       (front_item),
    .item_valid (front_valid),
    .item_ready (front_ready)
  );

  swd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_item  (front_item),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_item   (queue_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  swd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_item  (queue_item),
    .in_valid (queue_valid),
    .in_ready (queue_ready),
    .cfg      (cfg),
    .res      (res)
  );

endmodule

// File: rtl/swd_front.sv
// ----------------------------------------------------------------------------
// Serial wire debug host front end
// Accepts command requests, classifies them and registers them for the queue.
// ----------------------------------------------------------------------------
module swd_front (
  input  logic           clk,
  input  logic           rst,
  swd_cmd_if.sink        cmd,
  output swd_pkg::item_t item,
  output logic           item_valid,
  input  logic           item_ready
);

  swd_pkg::item_t classified;

  assign cmd.ready = !item_valid || item_ready;

  always_comb begin
    classified.start_ok = cmd.start_req && (cmd.opcode <= swd_pkg::OP_LRESET);
    classified.opcode   = cmd.opcode;
    classified.header   = cmd.request_header;
    classified.wdata    = cmd.write_data;
    classified.wpar     = swd_pkg::even_parity(cmd.write_data);
    classified.line_in  = cmd.line_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      item_valid <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
    if (cmd.valid && cmd.ready) begin
      item <= classified;
    end
  end

endmodule

// File: rtl/swd_queue.sv
// ----------------------------------------------------------------------------
// Serial wire debug host request queue
// Short first-in first-out queue between the front end and the engine.
// ----------------------------------------------------------------------------
module swd_queue (
  input  logic           clk,
  input  logic           rst,
  input  swd_pkg::item_t push_item,
  input  logic           push_valid,
  output logic           push_ready,
  output swd_pkg::item_t pop_item,
  output logic           pop_valid,
  input  logic           pop_ready
);

  swd_pkg::item_t             mem [swd_pkg::QUEUE_DEPTH];
  logic [swd_pkg::QPTR_W-1:0] wr_ptr;
  logic [swd_pkg::QPTR_W-1:0] rd_ptr;
  logic [swd_pkg::QPTR_W:0]   count;
  logic                       push;
  logic                       pop;

  assign push_ready = (count != (swd_pkg::QPTR_W+1)'(swd_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue fill count did not grow on a push");

  a_drain_shrinks: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue fill count did not shrink on a pop");

endmodule

// File: rtl/swd_back.sv
// ----------------------------------------------------------------------------
// Serial wire debug host engine
// Carries out one bit period per request and registers its result.
// ----------------------------------------------------------------------------
module swd_back (
  input  logic           clk,
  input  logic           rst,
  input  swd_pkg::item_t in_item,
  input  logic           in_valid,
  output logic           in_ready,
  swd_cfg_if.sink        cfg,
  swd_res_if.source      res
);

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_REQ    = 4'd1,
    PH_TRN1   = 4'd2,
    PH_ACK    = 4'd3,
    PH_RDATA  = 4'd4,
    PH_RPAR   = 4'd5,
    PH_RTRN   = 4'd6,
    PH_WTRN   = 4'd7,
    PH_WDATA  = 4'd8,
    PH_WPAR   = 4'd9,
    PH_WAIT   = 4'd10,
    PH_LRH1   = 4'd11,
    PH_LRSW   = 4'd12,
    PH_LRH2   = 4'd13,
    PH_LRIDLE = 4'd14
  } phase_t;

  phase_t                            phase, phase_next, cur;
  logic [swd_pkg::BC_W-1:0]          bit_count, bit_count_next;
  logic [swd_pkg::DATA_W-1:0]        shift_word, shift_word_next;
  logic [swd_pkg::HDR_W-1:0]         held_header, held_header_next;
  logic [swd_pkg::DATA_W-1:0]        held_write_word, held_write_word_next;
  logic                              held_wpar, held_wpar_next;
  logic [swd_pkg::OP_W-1:0]          held_opcode, held_opcode_next;
  logic [swd_pkg::ACK_W-1:0]         ack_bits, ack_bits_next;
  logic                              parity_acc, parity_acc_next;
  logic [swd_pkg::RETRY_W-1:0]       attempt_count, attempt_count_next;
  logic [swd_pkg::WAIT_W-1:0]        wait_count, wait_count_next;
  logic [swd_pkg::RETRY_W-1:0]       retry_limit;
  logic [swd_pkg::WAIT_W-1:0]        wait_ticks;

  logic [swd_pkg::RETRY_W-1:0]       attempt_inc;
  logic                              exhausted;
  logic                              waited;
  logic                              step;

  logic                              lo, drv, clk_act, busy, done;
  logic [swd_pkg::STATUS_W-1:0]      st;
  logic [swd_pkg::DATA_W-1:0]        rd;

  assign step      = in_valid && (!res.valid || res.ready);
  assign in_ready  = !res.valid || res.ready;
  assign cfg.ready = 1'b1;

  assign attempt_inc = (attempt_count != '1) ? attempt_count + 1'b1 : attempt_count;
  assign exhausted   = (attempt_inc >= retry_limit);

  always_comb begin
    phase_next           = phase;
    bit_count_next       = bit_count;
    shift_word_next      = shift_word;
    held_header_next     = held_header;
    held_write_word_next = held_write_word;
    held_wpar_next       = held_wpar;
    held_opcode_next     = held_opcode;
    ack_bits_next        = ack_bits;
    parity_acc_next      = parity_acc;
    attempt_count_next   = attempt_count;
    wait_count_next      = wait_count;
    lo      = 1'b0;
    drv     = 1'b1;
    clk_act = 1'b0;
    busy    = 1'b1;
    done    = 1'b0;
    st      = swd_pkg::ST_OK;
    rd      = '0;
    waited  = 1'b0;

    if (phase == PH_IDLE) begin
      if (in_item.start_ok) begin
        held_opcode_next     = in_item.opcode;
        held_header_next     = in_item.header;
        held_write_word_next = in_item.wdata;
        held_wpar_next       = in_item.wpar;
        attempt_count_next   = '0;
        bit_count_next       = '0;
        if (in_item.opcode == swd_pkg::OP_LRESET) begin
          phase_next = PH_LRH1;
        end else begin
          phase_next      = PH_REQ;
          ack_bits_next   = '0;
          parity_acc_next = 1'b0;
          shift_word_next = '0;
        end
      end else begin
        busy = 1'b0;
      end
    end

    cur = phase_next;
    case (cur)
      PH_IDLE: begin
      end
      PH_REQ: begin
        clk_act = 1'b1;
        lo = held_header_next[bit_count_next[2:0]];
        bit_count_next = bit_count_next + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::REQ_BITS)) begin
          phase_next = PH_TRN1;
          bit_count_next = '0;
        end
      end
      PH_TRN1: begin
        clk_act = 1'b1;
        drv = 1'b0;
        phase_next = PH_ACK;
        bit_count_next = '0;
      end
      PH_ACK: begin
        clk_act = 1'b1;
        drv = 1'b0;
        ack_bits_next = ack_bits | (swd_pkg::ACK_W'(in_item.line_in) << bit_count[1:0]);
        bit_count_next = bit_count + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::ACK_W)) begin
          bit_count_next = '0;
          if (held_opcode == swd_pkg::OP_WRITE) begin
            phase_next = PH_WTRN;
          end else if (ack_bits_next == swd_pkg::ACK_OK) begin
            phase_next = PH_RDATA;
          end else begin
            phase_next = PH_RTRN;
          end
        end
      end
      PH_RDATA: begin
        clk_act = 1'b1;
        drv = 1'b0;
        shift_word_next = shift_word |
                          (swd_pkg::DATA_W'(in_item.line_in) << bit_count[4:0]);
        parity_acc_next = parity_acc ^ in_item.line_in;
        bit_count_next = bit_count + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::DATA_W)) begin
          phase_next = PH_RPAR;
          bit_count_next = '0;
        end
      end
      PH_RPAR: begin
        clk_act = 1'b1;
        drv = 1'b0;
        parity_acc_next = parity_acc ^ in_item.line_in;
        phase_next = PH_RTRN;
      end
      PH_RTRN, PH_WTRN: begin
        clk_act = 1'b1;
        drv = 1'b0;
        if (cur == PH_RTRN && ack_bits == swd_pkg::ACK_OK && !parity_acc) begin
          done = 1'b1;
          rd = shift_word;
          phase_next = PH_IDLE;
        end else if (cur == PH_WTRN && ack_bits == swd_pkg::ACK_OK) begin
          phase_next = PH_WDATA;
          bit_count_next = '0;
        end else if (ack_bits == swd_pkg::ACK_OK || ack_bits == swd_pkg::ACK_WAIT) begin
          // Short of the retry limit, a bad read parity retries at once; a WAIT idles first if wait_ticks is nonzero.
          waited = (ack_bits == swd_pkg::ACK_WAIT);
          attempt_count_next = attempt_inc;
          if (exhausted) begin
            phase_next = PH_IDLE;
            done = 1'b1;
            st = swd_pkg::ST_EXHAUSTED;
          end else if (waited && wait_ticks != '0) begin
            phase_next = PH_WAIT;
            wait_count_next = wait_ticks;
          end else begin
            phase_next      = PH_REQ;
            bit_count_next  = '0;
            ack_bits_next   = '0;
            parity_acc_next = 1'b0;
            shift_word_next = '0;
          end
        end else begin
          done = 1'b1;
          st = swd_pkg::ST_FAULT;
          phase_next = PH_IDLE;
        end
      end
      PH_WDATA: begin
        clk_act = 1'b1;
        lo = held_write_word[bit_count[4:0]];
        bit_count_next = bit_count + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::DATA_W)) begin
          phase_next = PH_WPAR;
          bit_count_next = '0;
        end
      end
      PH_WPAR: begin
        clk_act = 1'b1;
        lo = held_wpar;
        done = 1'b1;
        phase_next = PH_IDLE;
      end
      PH_WAIT: begin
        if (wait_count != '0) begin
          wait_count_next = wait_count - 1'b1;
        end
        if (wait_count_next == '0) begin
          phase_next      = PH_REQ;
          bit_count_next  = '0;
          ack_bits_next   = '0;
          parity_acc_next = 1'b0;
          shift_word_next = '0;
        end
      end
      PH_LRH1, PH_LRH2: begin
        clk_act = 1'b1;
        lo = 1'b1;
        bit_count_next = bit_count_next + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::RESET_HIGH_BITS)) begin
          phase_next = (cur == PH_LRH1) ? PH_LRSW : PH_LRIDLE;
          bit_count_next = '0;
        end
      end
      PH_LRSW: begin
        clk_act = 1'b1;
        lo = swd_pkg::SWITCH_SEQ[bit_count[3:0]];
        bit_count_next = bit_count + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::SWITCH_BITS)) begin
          phase_next = PH_LRH2;
          bit_count_next = '0;
        end
      end
      PH_LRIDLE: begin
        clk_act = 1'b1;
        bit_count_next = bit_count + 1'b1;
        if (bit_count_next >= swd_pkg::BC_W'(swd_pkg::TRAIL_BITS)) begin
          done = 1'b1;
          phase_next = PH_IDLE;
          bit_count_next = '0;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bit_count       <= '0;
      shift_word      <= '0;
      held_header     <= '0;
      held_write_word <= '0;
      held_wpar       <= 1'b0;
      held_opcode     <= '0;
      ack_bits        <= '0;
      parity_acc      <= 1'b0;
      attempt_count   <= '0;
      wait_count      <= '0;
      retry_limit     <= swd_pkg::RETRY_LIMIT_RESET;
      wait_ticks      <= swd_pkg::WAIT_TICKS_RESET;
      res.valid       <= 1'b0;
    end else begin
      if (step) begin
        phase           <= phase_next;
        bit_count       <= bit_count_next;
        shift_word      <= shift_word_next;
        held_header     <= held_header_next;
        held_write_word <= held_write_word_next;
        held_wpar       <= held_wpar_next;
        held_opcode     <= held_opcode_next;
        ack_bits        <= ack_bits_next;
        parity_acc      <= parity_acc_next;
        attempt_count   <= attempt_count_next;
        wait_count      <= wait_count_next;
        res.valid       <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (cfg.valid) begin
        if (cfg.index == swd_pkg::CFG_RETRY_LIMIT) begin
          retry_limit <= cfg.data[swd_pkg::RETRY_W-1:0];
        end else if (cfg.index == swd_pkg::CFG_WAIT_TICKS) begin
          wait_ticks <= cfg.data[swd_pkg::WAIT_W-1:0];
        end
      end
    end
    if (step) begin
      res.line_out     <= lo;
      res.line_drive   <= drv;
      res.clock_active <= clk_act;
      res.busy_res     <= busy;
      res.done_res     <= done;
      res.status       <= st;
      res.read_data    <= rd;
    end
  end

  a_wait_unclocked: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_WAIT |=> res.valid && !res.clock_active && res.line_drive &&
                                 res.busy_res)
    else $error("wait period produced a clock pulse or released the line");

  a_flags_with_done: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.done_res |-> res.status == swd_pkg::ST_OK && res.read_data == '0)
    else $error("status or read data shown without completion");

  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_WPAR |=> res.done_res && res.status == swd_pkg::ST_OK &&
                                 phase == PH_IDLE)
    else $error("write parity period did not complete the command");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Testbench for the serial wire debug host transaction engine
// Drives one bit period per request, playing the target side on line_in:
// it answers with OK, WAIT or faulty acknowledges and with good or corrupted
// read parity. A bit-accurate predictor in the scoreboard works out every
// result, and each result is checked in order against that prediction. The
// retry and wait registers are taken through their extremes between phases.
// ----------------------------------------------------------------------------
typedef enum logic [3:0] {
  SEQ_IDLE, SEQ_REQUEST, SEQ_TURN, SEQ_ACK, SEQ_RD_DATA, SEQ_RD_PARITY, SEQ_RD_TURN,
  SEQ_WR_TURN, SEQ_WR_DATA, SEQ_WR_PARITY, SEQ_HOLD, SEQ_HIGH_A, SEQ_SWITCH, SEQ_HIGH_B,
  SEQ_TRAIL
} link_seq_e;

typedef struct packed {
  logic                       start_req;
  logic [swd_pkg::OP_W-1:0]   opcode;
  logic [swd_pkg::HDR_W-1:0]  request_header;
  logic [swd_pkg::DATA_W-1:0] write_data;
  logic                       line_in;
} bit_request_t;

typedef struct packed {
  logic                         line_out;
  logic                         line_drive;
  logic                         clock_active;
  logic                         busy_res;
  logic                         done_res;
  logic [swd_pkg::STATUS_W-1:0] status;
  logic [swd_pkg::DATA_W-1:0]   read_data;
} bit_period_t;

class swd_link_scoreboard;
  logic [swd_pkg::RETRY_W-1:0] retry_limit;
  logic [swd_pkg::WAIT_W-1:0]  wait_ticks;
  link_seq_e                   phase;
  logic [swd_pkg::BC_W-1:0]    bit_count;
  logic [swd_pkg::DATA_W-1:0]  shift_word;
  logic [swd_pkg::HDR_W-1:0]   held_header;
  logic [swd_pkg::DATA_W-1:0]  held_word;
  logic [swd_pkg::OP_W-1:0]    held_opcode;
  logic [swd_pkg::ACK_W-1:0]   ack_bits;
  logic                        parity_acc;
  logic [swd_pkg::RETRY_W-1:0] attempt_count;
  logic [swd_pkg::WAIT_W-1:0]  wait_count;
  bit_period_t                 expected_periods[$];
  int unsigned                 errors;

  function new();
    retry_limit = swd_pkg::RETRY_LIMIT_RESET;
    wait_ticks = swd_pkg::WAIT_TICKS_RESET;
    phase = SEQ_IDLE;
    bit_count = '0;
    shift_word = '0;
    held_header = '0;
    held_word = '0;
    held_opcode = '0;
    ack_bits = '0;
    parity_acc = 1'b0;
    attempt_count = '0;
    wait_count = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [swd_pkg::CFG_IDX_W-1:0] idx,
                        logic [swd_pkg::CFG_DATA_W-1:0] value);
    if (idx == swd_pkg::CFG_RETRY_LIMIT) begin
      retry_limit = value[swd_pkg::RETRY_W-1:0];
    end else if (idx == swd_pkg::CFG_WAIT_TICKS) begin
      wait_ticks = value[swd_pkg::WAIT_W-1:0];
    end
  endfunction

  function void start_attempt();
    phase = SEQ_REQUEST;
    bit_count = '0;
    ack_bits = '0;
    parity_acc = 1'b0;
    shift_word = '0;
  endfunction

  // Returns 1 when the failed attempt used up the last retry.
  function bit count_failed_attempt(bit waited);
    if (attempt_count != '1) attempt_count++;
    if (attempt_count >= retry_limit) begin
      phase = SEQ_IDLE;
      return 1'b1;
    end
    if (waited && wait_ticks != '0) begin
      phase = SEQ_HOLD;
      wait_count = wait_ticks;
    end else begin
      start_attempt();
    end
    return 1'b0;
  endfunction

  function void note_request(bit_request_t rq);
    bit_period_t r;
    r = '0;
    r.line_drive = 1'b1;
    r.busy_res = 1'b1;
    if (phase == SEQ_IDLE) begin
      if (rq.start_req && rq.opcode <= swd_pkg::OP_LRESET) begin
        held_opcode = rq.opcode;
        held_header = rq.request_header;
        held_word = rq.write_data;
        attempt_count = '0;
        if (rq.opcode == swd_pkg::OP_LRESET) begin
          phase = SEQ_HIGH_A;
          bit_count = '0;
        end else begin
          start_attempt();
        end
      end else begin
        r.busy_res = 1'b0;
      end
    end
    case (phase)
      SEQ_IDLE: begin
      end
      SEQ_REQUEST: begin
        r.clock_active = 1'b1;
        r.line_out = held_header[bit_count[2:0]];
        bit_count++;
        if (bit_count >= swd_pkg::REQ_BITS) begin
          phase = SEQ_TURN;
          bit_count = '0;
        end
      end
      SEQ_TURN: begin
        r.clock_active = 1'b1;
        r.line_drive = 1'b0;
        phase = SEQ_ACK;
        bit_count = '0;
      end
      SEQ_ACK: begin
        r.clock_active = 1'b1;
        r.line_drive = 1'b0;
        ack_bits |= swd_pkg::ACK_W'(rq.line_in) << bit_count[1:0];
        bit_count++;
        if (bit_count >= swd_pkg::ACK_W) begin
          bit_count = '0;
          if (held_opcode == swd_pkg::OP_WRITE) begin
            phase = SEQ_WR_TURN;
          end else if (ack_bits == swd_pkg::ACK_OK) begin
            phase = SEQ_RD_DATA;
          end else begin
            phase = SEQ_RD_TURN;
          end
        end
      end
      SEQ_RD_DATA: begin
        r.clock_active = 1'b1;
        r.line_drive = 1'b0;
        shift_word |= swd_pkg::DATA_W'(rq.line_in) << bit_count[4:0];
        parity_acc ^= rq.line_in;
        bit_count++;
        if (bit_count >= swd_pkg::DATA_W) begin
          phase = SEQ_RD_PARITY;
          bit_count = '0;
        end
      end
      SEQ_RD_PARITY: begin
        r.clock_active = 1'b1;
        r.line_drive = 1'b0;
        parity_acc ^= rq.line_in;
        phase = SEQ_RD_TURN;
      end
      SEQ_RD_TURN: begin
        r.clock_active = 1'b1;
        r.line_drive = 1'b0;
        if (ack_bits == swd_pkg::ACK_OK && !parity_acc) begin
          r.done_res = 1'b1;
          r.status = swd_pkg::ST_OK;
          r.read_data = shift_word;
          phase = SEQ_IDLE;
        end else if (ack_bits == swd_pkg::ACK_OK || ack_bits == swd_pkg::ACK_WAIT) begin
          if (count_failed_attempt(ack_bits == swd_pkg::ACK_WAIT)) begin
            r.done_res = 1'b1;
            r.status = swd_pkg::ST_EXHAUSTED;
          end
        end else begin
          r.done_res = 1'b1;
          r.status = swd_pkg::ST_FAULT;
          phase = SEQ_IDLE;
        end
      end
      SEQ_WR_TURN: begin
        r.clock_active = 1'b1;
        r.line_drive = 1'b0;
        if (ack_bits == swd_pkg::ACK_OK) begin
          phase = SEQ_WR_DATA;
          bit_count = '0;
        end else if (ack_bits == swd_pkg::ACK_WAIT) begin
          if (count_failed_attempt(1'b1)) begin
            r.done_res = 1'b1;
            r.status = swd_pkg::ST_EXHAUSTED;
          end
        end else begin
          r.done_res = 1'b1;
          r.status = swd_pkg::ST_FAULT;
          phase = SEQ_IDLE;
        end
      end
      SEQ_WR_DATA: begin
        r.clock_active = 1'b1;
        r.line_out = held_word[bit_count[4:0]];
        bit_count++;
        if (bit_count >= swd_pkg::DATA_W) begin
          phase = SEQ_WR_PARITY;
          bit_count = '0;
        end
      end
      SEQ_WR_PARITY: begin
        r.clock_active = 1'b1;
        r.line_out = ^held_word;
        r.done_res = 1'b1;
        r.status = swd_pkg::ST_OK;
        phase = SEQ_IDLE;
      end
      SEQ_HOLD: begin
        if (wait_count != '0) wait_count--;
        if (wait_count == '0) start_attempt();
      end
      SEQ_HIGH_A, SEQ_HIGH_B: begin
        r.clock_active = 1'b1;
        r.line_out = 1'b1;
        bit_count++;
        if (bit_count >= swd_pkg::RESET_HIGH_BITS) begin
          if (phase == SEQ_HIGH_A) begin
            phase = SEQ_SWITCH;
          end else begin
            phase = SEQ_TRAIL;
          end
          bit_count = '0;
        end
      end
      SEQ_SWITCH: begin
        r.clock_active = 1'b1;
        r.line_out = swd_pkg::SWITCH_SEQ[bit_count[3:0]];
        bit_count++;
        if (bit_count >= swd_pkg::SWITCH_BITS) begin
          phase = SEQ_HIGH_B;
          bit_count = '0;
        end
      end
      SEQ_TRAIL: begin
        r.clock_active = 1'b1;
        bit_count++;
        if (bit_count >= swd_pkg::TRAIL_BITS) begin
          r.done_res = 1'b1;
          r.status = swd_pkg::ST_OK;
          phase = SEQ_IDLE;
          bit_count = '0;
        end
      end
      default: begin
        phase = SEQ_IDLE;
        r.busy_res = 1'b0;
      end
    endcase
    expected_periods.push_back(r);
  endfunction

  function string show(bit_period_t r);
    return $sformatf("out=%b drive=%b clk=%b busy=%b done=%b status=%0d read=%h",
                     r.line_out, r.line_drive, r.clock_active, r.busy_res, r.done_res,
                     r.status, r.read_data);
  endfunction

  function void check_period(bit_period_t got);
    bit_period_t want;
    if (expected_periods.size() == 0) begin
      errors++;
      $display("%0t: result with nothing expected: %s", $time, show(got));
      return;
    end
    want = expected_periods.pop_front();
    if (got !== want) begin
      errors++;
      $display("%0t: mismatch, expected %s", $time, show(want));
      $display("%0t:           actual   %s", $time, show(got));
    end
  endfunction
endclass

module tb;
  localparam logic [swd_pkg::OP_W-1:0]  OP_UNUSED    = 2'd3;
  localparam logic [swd_pkg::ACK_W-1:0] ACK_FAULT    = 3'b100;
  localparam logic [swd_pkg::ACK_W-1:0] ACK_NO_REPLY = 3'b000;
  localparam logic [swd_pkg::ACK_W-1:0] ACK_FLOATING = 3'b111;

  logic clk = 1'b0;
  logic rst;

  swd_cmd_if cmd_bus();
  swd_res_if res_bus();
  swd_cfg_if cfg_bus();

  swd_host_transaction_engine_unit uut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_bus),
    .res(res_bus),
    .cfg(cfg_bus)
  );

  swd_link_scoreboard          sb;
  bit_request_t                cur_req;
  bit_request_t                command_plan[$];
  logic [swd_pkg::ACK_W-1:0]   ack_plan[$];
  bit                          parity_plan[$];
  logic [swd_pkg::ACK_W-1:0]   cur_ack;
  int unsigned                 ok_pct = 70;
  int unsigned                 wait_pct = 15;
  int unsigned                 parity_err_pct = 10;
  int unsigned                 total_sent = 0;
  int unsigned                 total_received = 0;
  int unsigned                 holdoff = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("[swd_host_transaction_engine_unit] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        sb.check_period({res_bus.line_out, res_bus.line_drive, res_bus.clock_active,
                         res_bus.busy_res, res_bus.done_res, res_bus.status,
                         res_bus.read_data});
        total_received++;
        if (total_received == 150 || total_received == 1000) holdoff = 40;
      end
      if (holdoff != 0) begin
        holdoff--;
        res_bus.ready <= 1'b0;
      end else if (total_received >= 300 && total_received < 700) begin
        res_bus.ready <= 1'b1;
      end else begin
        res_bus.ready <= $urandom_range(99) >= 25;
      end
    end
  end

  function automatic void plan_command(logic [swd_pkg::OP_W-1:0] op,
                                       logic [swd_pkg::HDR_W-1:0] hdr,
                                       logic [swd_pkg::DATA_W-1:0] word);
    bit_request_t rq;
    rq = '0;
    rq.start_req = 1'b1;
    rq.opcode = op;
    rq.request_header = hdr;
    rq.write_data = word;
    command_plan.push_back(rq);
  endfunction

  function automatic logic [swd_pkg::ACK_W-1:0] pick_ack();
    int unsigned roll;
    logic [swd_pkg::ACK_W-1:0] v;
    if (ack_plan.size() != 0) return ack_plan.pop_front();
    roll = $urandom_range(99);
    if (roll < ok_pct) return swd_pkg::ACK_OK;
    if (roll < ok_pct + wait_pct) return swd_pkg::ACK_WAIT;
    v = swd_pkg::ACK_W'($urandom_range(7));
    if (v == swd_pkg::ACK_OK || v == swd_pkg::ACK_WAIT) v = ACK_FAULT;
    return v;
  endfunction

  // The target's answer on line_in follows the phase the engine is in.
  function automatic bit_request_t next_request(bit fresh);
    bit_request_t rq;
    bit corrupt;
    int unsigned roll;
    rq.start_req = 1'($urandom_range(1));
    rq.opcode = swd_pkg::OP_W'($urandom_range(3));
    rq.request_header = swd_pkg::HDR_W'($urandom);
    rq.write_data = $urandom;
    rq.line_in = 1'($urandom_range(1));
    if (sb.phase == SEQ_IDLE) begin
      if (command_plan.size() != 0) begin
        rq = command_plan.pop_front();
        rq.line_in = 1'($urandom_range(1));
      end else if (!fresh) begin
        rq.start_req = 1'b0;
      end else begin
        rq.start_req = $urandom_range(99) < 88;
        roll = $urandom_range(99);
        if (roll < 2) rq.opcode = swd_pkg::OP_LRESET;
        else if (roll < 6) rq.opcode = OP_UNUSED;
        else if (roll < 53) rq.opcode = swd_pkg::OP_READ;
        else rq.opcode = swd_pkg::OP_WRITE;
      end
    end else if (sb.phase == SEQ_ACK) begin
      if (sb.bit_count == '0) cur_ack = pick_ack();
      rq.line_in = cur_ack[sb.bit_count[1:0]];
    end else if (sb.phase == SEQ_RD_PARITY) begin
      if (parity_plan.size() != 0) corrupt = parity_plan.pop_front();
      else corrupt = $urandom_range(99) < parity_err_pct;
      rq.line_in = sb.parity_acc ^ corrupt;
    end
    return rq;
  endfunction

  task automatic drive_requests(input int unsigned n_random);
    int unsigned sent;
    bit finished;
    sent = 0;
    finished = 1'b0;
    while (!finished) begin
      @(posedge clk);
      if (cmd_bus.valid && cmd_bus.ready) begin
        sb.note_request(cur_req);
        sent++;
        total_sent++;
      end
      if (cmd_bus.valid && !cmd_bus.ready) continue;
      if (sent >= n_random && command_plan.size() == 0 && sb.phase == SEQ_IDLE) begin
        cmd_bus.valid <= 1'b0;
        finished = 1'b1;
      end else if ((total_sent < 300 || total_sent >= 700) && $urandom_range(99) < 25) begin
        cmd_bus.valid <= 1'b0;
      end else begin
        cur_req = next_request(sent < n_random);
        cmd_bus.valid <= 1'b1;
        cmd_bus.start_req <= cur_req.start_req;
        cmd_bus.opcode <= cur_req.opcode;
        cmd_bus.request_header <= cur_req.request_header;
        cmd_bus.write_data <= cur_req.write_data;
        cmd_bus.line_in <= cur_req.line_in;
      end
    end
  endtask

  task automatic settle();
    while (sb.expected_periods.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swd_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  initial begin
    rst <= 1'b1;
    cmd_bus.valid <= 1'b0;
    cmd_bus.start_req <= 1'b0;
    cmd_bus.opcode <= swd_pkg::OP_READ;
    cmd_bus.request_header <= '0;
    cmd_bus.write_data <= '0;
    cmd_bus.line_in <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= swd_pkg::CFG_RETRY_LIMIT;
    cfg_bus.data <= '0;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset values: every acknowledge kind, a WAIT retry, a bad read parity,
    // the unused opcode and a line reset.
    plan_command(swd_pkg::OP_READ, 8'hA5, 32'h0);
    plan_command(swd_pkg::OP_WRITE, 8'hFF, 32'hFFFF_FFFF);
    plan_command(swd_pkg::OP_WRITE, 8'h00, 32'h0000_0000);
    plan_command(swd_pkg::OP_READ, 8'h8D, 32'h1234_5678);
    plan_command(swd_pkg::OP_WRITE, 8'hB1, 32'hDEAD_BEEF);
    plan_command(swd_pkg::OP_READ, 8'h9F, 32'h0);
    plan_command(swd_pkg::OP_READ, 8'hA5, 32'h0);
    plan_command(swd_pkg::OP_WRITE, 8'h81, 32'h8000_0001);
    plan_command(swd_pkg::OP_READ, 8'hBD, 32'h0);
    plan_command(OP_UNUSED, 8'hA5, 32'h0);
    plan_command(swd_pkg::OP_LRESET, 8'h00, 32'h0);
    plan_command(swd_pkg::OP_READ, 8'h81, 32'h0);
    ack_plan = '{swd_pkg::ACK_OK, swd_pkg::ACK_OK, swd_pkg::ACK_OK, ACK_FAULT,
                 ACK_FLOATING, ACK_NO_REPLY, swd_pkg::ACK_WAIT, swd_pkg::ACK_OK,
                 swd_pkg::ACK_WAIT, swd_pkg::ACK_OK, swd_pkg::ACK_OK, swd_pkg::ACK_OK,
                 swd_pkg::ACK_OK};
    parity_plan = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
    drive_requests(0);
    drive_requests(200);
    settle();

    write_reg(swd_pkg::CFG_RETRY_LIMIT, 16'h0001);
    write_reg(swd_pkg::CFG_WAIT_TICKS, 16'h0000);
    ok_pct = 50;
    wait_pct = 30;
    parity_err_pct = 20;
    drive_requests(130);
    settle();

    // The upper byte of the retry register write is dropped.
    write_reg(swd_pkg::CFG_RETRY_LIMIT, 16'hA5FF);
    plan_command(swd_pkg::OP_READ, 8'hA5, 32'h0);
    ack_plan = '{swd_pkg::ACK_WAIT, swd_pkg::ACK_WAIT, swd_pkg::ACK_OK};
    parity_plan = '{1'b0};
    drive_requests(0);
    settle();
    write_reg(swd_pkg::CFG_RETRY_LIMIT, 16'hA503);
    plan_command(swd_pkg::OP_READ, 8'hA5, 32'h0);
    repeat (3) ack_plan.push_back(swd_pkg::ACK_WAIT);
    drive_requests(0);
    ok_pct = 60;
    wait_pct = 30;
    parity_err_pct = 10;
    drive_requests(130);
    settle();

    // A zero retry limit gives up after the first attempt.
    write_reg(swd_pkg::CFG_RETRY_LIMIT, 16'h0000);
    write_reg(swd_pkg::CFG_WAIT_TICKS, 16'hFFFF);
    plan_command(swd_pkg::OP_READ, 8'hA5, 32'h0);
    plan_command(swd_pkg::OP_WRITE, 8'hB1, 32'h5A5A_A5A5);
    ack_plan = '{swd_pkg::ACK_WAIT, swd_pkg::ACK_WAIT};
    drive_requests(0);
    settle();
    write_reg(swd_pkg::CFG_RETRY_LIMIT, 16'h0003);
    write_reg(swd_pkg::CFG_WAIT_TICKS, 16'h0018);
    plan_command(swd_pkg::OP_READ, 8'h8D, 32'h0);
    ack_plan = '{swd_pkg::ACK_WAIT, swd_pkg::ACK_OK};
    parity_plan = '{1'b0};
    drive_requests(0);
    settle();

    write_reg(swd_pkg::CFG_RETRY_LIMIT, {8'($urandom_range(255)), 8'($urandom_range(2, 8))});
    write_reg(swd_pkg::CFG_WAIT_TICKS, 16'($urandom_range(20)));
    ok_pct = 60;
    wait_pct = 25;
    parity_err_pct = 15;
    drive_requests(170);
    settle();

    if (sb.errors == 0) begin
      $display("[swd_host_transaction_engine_unit] OK");
    end else begin
      $display("[swd_host_transaction_engine_unit] ERROR");
    end
    $finish;
  end
endmodule
